[design/mwrd_pkg.sv]
package mwrd_pkg;

  localparam int unsigned LOC_W         = 8;
  localparam int unsigned ADDR_BITS_W   = 4;
  localparam int unsigned CMD_W         = 13;
  localparam int unsigned ACC_W         = 29;
  localparam int unsigned DATA_BITS_DEF = 16;

  localparam logic [ADDR_BITS_W-1:0] ADDR_BITS_RST = 4'd6;
  localparam logic [ADDR_BITS_W-1:0] ADDR_BITS_MIN = 4'd6;
  localparam logic [ADDR_BITS_W-1:0] ADDR_BITS_MAX = 4'd8;

  // READ opcode: start bit plus "10"
  localparam logic [2:0] OPCODE_READ = 3'b110;
  // start bit, two opcode bits and two zero slots sent ahead of the start bit
  localparam int unsigned CMD_OVERHEAD = 5;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_RAISE  = 8'b0000_0010,
    PH_CMD_LO = 8'b0000_0100,
    PH_CMD_HI = 8'b0000_1000,
    PH_GAP    = 8'b0001_0000,
    PH_DAT_HI = 8'b0010_0000,
    PH_DAT_LO = 8'b0100_0000,
    PH_CLOSE  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic             chip_select;
    logic             shift_clock;
    logic             data_in_pin;
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] read_value;
  } mwrd_result_t;

endpackage

[design/mwrd_core.sv]
module mwrd_core import mwrd_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_en_i,
  input  logic                   cmd_i,
  input  logic [LOC_W-1:0]       location_i,
  input  logic                   data_out_pin_i,
  input  logic [ADDR_BITS_W-1:0] addr_bits_i,
  output mwrd_result_t           result_o
);

  localparam int unsigned CmdSlotsMax = CMD_OVERHEAD + 8;
  localparam int unsigned CntMax = (DATA_BITS > CmdSlotsMax) ? DATA_BITS : CmdSlotsMax;
  localparam int unsigned CntW   = $clog2(CntMax + 1);

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [CMD_W-1:0]  cmd_word_q, cmd_word_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [2:0]        pins_q, pins_d;   // {DI, SK, CS}
  logic              pend_q, pend_d;

  logic [ADDR_BITS_W-1:0] len_sat;
  logic [CntW-1:0]        bit_idx;
  logic [CMD_W-1:0]       cmd_shifted;
  logic                   cmd_bit;
  logic                   done;

  always_comb begin
    if (addr_bits_i < ADDR_BITS_MIN) begin
      len_sat = ADDR_BITS_MIN;
    end else if (addr_bits_i > ADDR_BITS_MAX) begin
      len_sat = ADDR_BITS_MAX;
    end else begin
      len_sat = addr_bits_i;
    end
  end

  assign bit_idx     = bit_cnt_q - CntW'(1);
  assign cmd_shifted = cmd_word_q >> bit_idx;
  assign cmd_bit     = (bit_cnt_q != '0) && cmd_shifted[0];

  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    cmd_word_d = cmd_word_q;
    acc_d      = acc_q;
    pins_d     = pins_q;
    pend_d     = pend_q;
    done       = 1'b0;

    if (!cmd_i) begin
      // start: ignored unless idle
      if (phase_q == PH_IDLE) begin
        cmd_word_d = {{(CMD_W-LOC_W){1'b0}}, location_i}
                   | (CMD_W'(OPCODE_READ) << len_sat);
        bit_cnt_d  = CntW'(CMD_OVERHEAD) + CntW'(len_sat);
        acc_d      = '0;
        pend_d     = 1'b0;
        pins_d     = 3'b000;
        phase_d    = PH_RAISE;
      end
    end else begin
      if (pend_q) begin
        acc_d  = {acc_q[ACC_W-2:0], data_out_pin_i};
        pend_d = 1'b0;
      end
      case (phase_q)
        PH_IDLE: begin
        end
        PH_RAISE: begin
          pins_d  = 3'b001;
          phase_d = PH_CMD_LO;
        end
        PH_CMD_LO: begin
          pins_d  = {cmd_bit, 2'b01};
          phase_d = PH_CMD_HI;
        end
        PH_CMD_HI: begin
          pins_d = {cmd_bit, 2'b11};
          pend_d = 1'b1;
          if (bit_cnt_q <= CntW'(1)) begin
            bit_cnt_d = CntW'(DATA_BITS);
            phase_d   = PH_GAP;
          end else begin
            bit_cnt_d = bit_cnt_q - CntW'(1);
            phase_d   = PH_CMD_LO;
          end
        end
        PH_GAP: begin
          pins_d  = 3'b001;
          phase_d = PH_DAT_HI;
        end
        PH_DAT_HI: begin
          pins_d = 3'b011;
          pend_d = 1'b1;
          if (bit_cnt_q != '0) begin
            bit_cnt_d = bit_cnt_q - CntW'(1);
          end
          phase_d = PH_DAT_LO;
        end
        PH_DAT_LO: begin
          pins_d  = 3'b001;
          phase_d = (bit_cnt_q == '0) ? PH_CLOSE : PH_DAT_HI;
        end
        PH_CLOSE: begin
          pins_d  = 3'b000;
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result_o.chip_select = pins_d[0];
    result_o.shift_clock = pins_d[1];
    result_o.data_in_pin = pins_d[2];
    result_o.busy        = (phase_d != PH_IDLE);
    result_o.done        = done;
    result_o.read_value  = done ? acc_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= '0;
      cmd_word_q <= '0;
      acc_q      <= '0;
      pins_q     <= 3'b000;
      pend_q     <= 1'b0;
    end else if (step_en_i) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      cmd_word_q <= cmd_word_d;
      acc_q      <= acc_d;
      pins_q     <= pins_d;
      pend_q     <= pend_d;
    end
  end

  // Pins stay low whenever no access is open.
  a_idle_pins_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> pins_q == 3'b000)
    else $error("pins driven while idle");

  // Done comes only out of the closing step.
  a_done_from_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.done |-> (phase_q == PH_CLOSE && cmd_i))
    else $error("done outside closing step");

  // The slot counter never runs past the longest phase.
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= CntW'(CntMax))
    else $error("slot counter out of range");

endmodule

[design/microwire_eeprom_read_sequencer.sv]
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+--------------------------------------
// in       | input     | in_valid_i / in_stall_o    | cmd_i, location_i, data_out_pin_i
// out      | output    | out_valid_o / out_stall_i  | chip_select_o, shift_clock_o,
//          |           |                            | data_in_pin_o, busy_res_o,
//          |           |                            | done_res_o, read_value_o
// cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_addr_bits_i
//
// Each input transfer yields exactly one result transfer from the output register.
// One item per cycle is sustained while the consumer does not stall; the sequencer
// step is a single pass of next-state logic between the state registers and the
// result register. Reset (rst_ni low, asynchronous) returns the core to idle with
// its pins low and the address length at 6; the result register is not reset.
// in_stall_o rises only while a result sits in the output register and the
// consumer stalls it; the next item is taken in the same cycle the waiting result leaves.
module microwire_eeprom_read_sequencer import mwrd_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [ADDR_BITS_W-1:0] cfg_addr_bits_i,
  // input items
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   cmd_i,
  input  logic [LOC_W-1:0]       location_i,
  input  logic                   data_out_pin_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   chip_select_o,
  output logic                   shift_clock_o,
  output logic                   data_in_pin_o,
  output logic                   busy_res_o,
  output logic                   done_res_o,
  output logic [ACC_W-1:0]       read_value_o
);

  logic [ADDR_BITS_W-1:0] addr_bits_q;
  logic                   out_valid_q, out_valid_d;
  mwrd_result_t           res_q, res_d;
  logic                   in_accept;

  // Always writable; software must write the register only between accesses, unchecked.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_bits_q <= ADDR_BITS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      addr_bits_q <= cfg_addr_bits_i;
    end
  end

  // Stall the producer only while a finished result is held by the consumer.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  mwrd_core #(
    .DATA_BITS(DATA_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (in_accept),
    .cmd_i         (cmd_i),
    .location_i    (location_i),
    .data_out_pin_i(data_out_pin_i),
    .addr_bits_i   (addr_bits_q),
    .result_o      (res_d)
  );

  // Output register: load on every accepted item, drop once transferred.
  always_comb begin
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chip_select_o = res_q.chip_select;
  assign shift_clock_o = res_q.shift_clock;
  assign data_in_pin_o = res_q.data_in_pin;
  assign busy_res_o    = res_q.busy;
  assign done_res_o    = res_q.done;
  assign read_value_o  = res_q.read_value;

  // Every accepted item shows up as a result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted item produced no result");

  // A held result is never dropped while the consumer stalls.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result lost");

  // Sampled data is shown only together with done.
  a_value_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.done) |-> res_q.read_value == '0)
    else $error("read value without done");

endmodule
